// ===== sv/bvm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types, register indexes and constants of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

    // field widths
    localparam int ADC_W   = 12;
    localparam int TIME_W  = 32;
    localparam int MV_W    = 16;
    localparam int SCALE_W = 20;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    // moving average store, depth is a power of two
    localparam int AVG_SHIFT = 3;
    localparam int AVG_DEPTH = 1 << AVG_SHIFT;
    localparam int SUM_W     = MV_W + AVG_SHIFT;

    // bit-serial multiplier: one adc bit per cycle
    localparam int MUL_CNT_W = $clog2(ADC_W);
    localparam int PROD_W    = ADC_W + SCALE_W;

    // percent divider: one quotient bit per cycle
    localparam int PCT_SCALE  = 100;
    localparam int NUM_W      = MV_W + PCT_W;
    localparam int DIV_CNT_W  = $clog2(PCT_W);

    // warning hold-off in ms
    localparam logic [TIME_W-1:0] WARN_HOLDOFF_MS = 32'd10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MV_PER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SHUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd6;

    // register reset values
    localparam logic [SCALE_W-1:0] RST_MV_PER_COUNT = 20'd52813;
    localparam logic [MV_W-1:0]    RST_BATT_MIN     = 16'd3300;
    localparam logic [MV_W-1:0]    RST_BATT_MAX     = 16'd4200;
    localparam logic [MV_W-1:0]    RST_ALARM_LOW    = 16'd3500;
    localparam logic [MV_W-1:0]    RST_SHUTDOWN     = 16'd3300;
    localparam logic [MV_W-1:0]    RST_INTERVAL     = 16'd1000;

    // input word
    typedef struct packed {
        logic [ADC_W-1:0]  adc_value;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              updated;
        logic [MV_W-1:0]   raw_mv;
        logic [MV_W-1:0]   avg_mv;
        logic [PCT_W-1:0]  percent;
        logic              is_low;
        logic              is_critical;
        logic              warning_event;
        logic              shutdown_event;
    } t_out_word;

    // divider handshake between top and divider
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage
`default_nettype wire

// ===== sv/bvm_pct_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pct_div
// Restoring divider for the charge percent, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvm_pct_div
    import bvm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [MV_W-1:0]   i_den,
    output logic                   o_done,
    output logic [PCT_W-1:0]       o_quot
);

    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dvs;
    logic [PCT_W-1:0]     r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 n_fits;

    // trial subtract of the shifted divisor
    assign n_fits = (r_rem >= r_dvs);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PCT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dvs  <= {1'b0, i_den, {(PCT_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (n_fits) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quot <= {r_quot[PCT_W-2:0], n_fits};
            r_dvs  <= r_dvs >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== sv/battery_voltage_monitor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// Moving-average battery monitor with percent, low warning and shutdown.
// ----------------------------------------------------------------------------
// Works one word at a time. An accepted sample goes from the input handshake
// through the bit-serial scale multiplier (one adc bit per cycle), the average
// store, the thresholds, the step that forms the divider numerator, the percent
// divider and its done flag, and the load of the output register. A sample
// inside the update interval skips the multiplier and the store. The input
// stalls from the handshake until the result is loaded, so a new word is not
// taken before the last one is through. The result waits in an output
// register; the next word is taken while it waits.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_core
    import bvm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_data,
    // result words
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_data,
    // register writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_AVG   = 7'b0000100,
        ST_FLAG  = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    // registers
    logic [SCALE_W-1:0]   r_mv_per_count;
    logic [MV_W-1:0]      r_batt_min;
    logic [MV_W-1:0]      r_batt_max;
    logic [MV_W-1:0]      r_alarm_low;
    logic [MV_W-1:0]      r_shutdown;
    logic                 r_auto_shut;
    logic [MV_W-1:0]      r_interval;

    // state
    t_state               r_state;
    t_state               n_state;
    logic [MV_W-1:0]      r_store [AVG_DEPTH];
    logic [AVG_SHIFT-1:0] r_slot;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic                 r_primed;
    logic [TIME_W-1:0]    r_last_upd;
    logic [TIME_W-1:0]    r_last_warn;
    logic                 r_warn_off;
    logic                 r_crit_latched;
    logic [MV_W-1:0]      r_held_raw;
    logic [MV_W-1:0]      r_held_avg;

    // per word working registers
    logic [TIME_W-1:0]    r_now;
    logic                 r_accept;
    logic [PROD_W-1:0]    r_prod;
    logic [MUL_CNT_W-1:0] r_mul_cnt;
    logic [SCALE_W:0]     n_part;
    logic [MV_W-1:0]      n_mv;
    logic                 r_low;
    logic                 r_crit;
    logic                 r_warn;
    logic                 r_shut;
    logic [MV_W-1:0]      r_diff;
    logic [MV_W-1:0]      r_den;
    logic                 r_span_ok;
    logic [NUM_W-1:0]     n_num;
    logic [MV_W-1:0]      n_clamp;
    logic                 n_low;
    logic                 n_crit;
    logic                 n_in_take;
    logic                 n_out_take;
    logic                 n_due;

    // output register
    logic                 r_out_valid;
    t_out_word            r_out;

    t_div_ctl             div_ctl;
    logic [PCT_W-1:0]     div_quot;

    assign n_in_take  = i_valid && !o_stall;
    assign n_out_take = r_out_valid && !i_stall;
    assign n_due      = !r_primed ||
                        ((i_data.now_ms - r_last_upd) >= {16'd0, r_interval});

    // register write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_per_count <= RST_MV_PER_COUNT;
            r_batt_min     <= RST_BATT_MIN;
            r_batt_max     <= RST_BATT_MAX;
            r_alarm_low    <= RST_ALARM_LOW;
            r_shutdown     <= RST_SHUTDOWN;
            r_auto_shut    <= 1'b1;
            r_interval     <= RST_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MV_PER_COUNT: r_mv_per_count <= i_cfg_wdata;
                CFG_BATT_MIN:     r_batt_min     <= i_cfg_wdata[MV_W-1:0];
                CFG_BATT_MAX:     r_batt_max     <= i_cfg_wdata[MV_W-1:0];
                CFG_ALARM_LOW:    r_alarm_low    <= i_cfg_wdata[MV_W-1:0];
                CFG_SHUTDOWN:     r_shutdown     <= i_cfg_wdata[MV_W-1:0];
                CFG_AUTO_SHUT:    r_auto_shut    <= i_cfg_wdata[0];
                CFG_INTERVAL:     r_interval     <= i_cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = n_due ? ST_MUL : ST_FLAG;
            ST_MUL:   if (r_mul_cnt == '0) n_state = ST_AVG;
            ST_AVG:   n_state = ST_FLAG;
            ST_FLAG:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DIV;
            ST_DIV:   if (div_ctl.done) n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    // take the word
    always_ff @(posedge i_clk) begin
        if (n_in_take) begin
            r_now    <= i_data.now_ms;
            r_accept <= n_due;
        end
    end

    // bit-serial scale multiply, lsb of the adc value first
    assign n_part = {1'b0, r_prod[PROD_W-1:ADC_W]}
                  + (r_prod[0] ? {1'b0, r_mv_per_count} : '0);
    // product of 12 by 20 bits never exceeds 32 bits, so no saturation hit
    assign n_mv   = r_prod[PROD_W-1:PROD_W-MV_W];

    always_ff @(posedge i_clk) begin
        if (n_in_take) begin
            r_prod    <= {{SCALE_W{1'b0}}, i_data.adc_value};
            r_mul_cnt <= MUL_CNT_W'(ADC_W - 1);
        end else if (r_state == ST_MUL) begin
            r_prod    <= {n_part, r_prod[ADC_W-1:1]};
            r_mul_cnt <= r_mul_cnt - 1'b1;
        end
    end

    // average store update
    assign n_sum = r_primed ? (r_sum - {{AVG_SHIFT{1'b0}}, r_store[r_slot]}
                               + {{AVG_SHIFT{1'b0}}, n_mv})
                            : {n_mv, {AVG_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_AVG) begin
            for (int k = 0; k < AVG_DEPTH; k++) begin
                if (!r_primed || (r_slot == AVG_SHIFT'(k))) begin
                    r_store[k] <= n_mv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_sum      <= '0;
            r_primed   <= 1'b0;
            r_last_upd <= '0;
            r_held_raw <= '0;
            r_held_avg <= '0;
        end else if (r_state == ST_AVG) begin
            r_slot     <= r_primed ? r_slot + 1'b1 : '0;
            r_sum      <= n_sum;
            r_primed   <= 1'b1;
            r_last_upd <= r_now;
            r_held_raw <= n_mv;
            r_held_avg <= n_sum[SUM_W-1:AVG_SHIFT];
        end
    end

    // thresholds, warning and shutdown
    assign n_low  = (r_held_avg <= r_alarm_low);
    assign n_crit = (r_held_avg <= r_shutdown);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_warn    <= '0;
            r_warn_off     <= 1'b0;
            r_crit_latched <= 1'b0;
            r_warn         <= 1'b0;
            r_shut         <= 1'b0;
        end else if (r_state == ST_FLAG) begin
            r_warn <= 1'b0;
            r_shut <= 1'b0;
            if (r_accept) begin
                if (n_low && !r_warn_off
                    && ((r_now - r_last_warn) >= WARN_HOLDOFF_MS)) begin
                    r_warn      <= 1'b1;
                    r_last_warn <= r_now;
                    r_warn_off  <= 1'b1;
                end else if (!n_low && r_warn_off) begin
                    r_warn_off  <= 1'b0;
                end
                if (r_auto_shut && n_crit && !r_crit_latched) begin
                    r_crit_latched <= 1'b1;
                    r_shut         <= 1'b1;
                end
            end
        end
    end

    // clamp the average into the span
    always_comb begin
        n_clamp = r_held_avg;
        if (n_clamp < r_batt_min) n_clamp = r_batt_min;
        if (n_clamp > r_batt_max) n_clamp = r_batt_max;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FLAG) begin
            r_low     <= n_low;
            r_crit    <= n_crit;
            r_diff    <= n_clamp - r_batt_min;
            r_den     <= r_batt_max - r_batt_min;
            r_span_ok <= (r_batt_max > r_batt_min);
        end
    end

    // numerator diff * 100 as shifted adds
    assign n_num = ({{PCT_W{1'b0}}, r_diff} << 6)
                 + ({{PCT_W{1'b0}}, r_diff} << 5)
                 + ({{PCT_W{1'b0}}, r_diff} << 2);

    assign div_ctl.start = (r_state == ST_SCALE);

    bvm_pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_ctl.start),
        .i_num   (n_num),
        .i_den   (r_den),
        .o_done  (div_ctl.done),
        .o_quot  (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && (!r_out_valid || !i_stall)) begin
            r_out_valid <= 1'b1;
        end else if (n_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_out_valid || !i_stall)) begin
            r_out.updated        <= r_accept;
            r_out.raw_mv         <= r_held_raw;
            r_out.avg_mv         <= r_held_avg;
            r_out.percent        <= r_span_ok ? div_quot : '0;
            r_out.is_low         <= r_low;
            r_out.is_critical    <= r_crit;
            r_out.warning_event  <= r_warn;
            r_out.shutdown_event <= r_shut;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.percent <= 7'd100))
        else $error("percent above 100");

    a_shut_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.shutdown_event) |-> (o_data.updated && o_data.is_critical))
        else $error("shutdown event without critical update");

    a_warn_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.warning_event) |-> (o_data.updated && o_data.is_low))
        else $error("warning event without low update");

    a_latch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crit_latched |=> r_crit_latched)
        else $error("shutdown latch cleared without reset");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_voltage_monitor_core. A queue-fed driver
// offers sample words with random gaps, a monitor takes result words under
// random back-pressure, and every result is checked against an in-bench model
// of the scaler, moving average, percent map, low warning and shutdown latch.
// ----------------------------------------------------------------------------
module tb;
    import bvm_pkg::*;

    // register index past the end of the list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int IDLE_PCT     = 30;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 400;
    localparam int PHASE_WORDS  = 150;
    localparam int NUM_PHASES   = 8;

    // dut inputs, all known from time zero
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // dut outputs
    logic      o_stall;
    logic      o_valid;
    t_out_word o_data;

    battery_voltage_monitor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_stall     (o_stall),
        .i_data      (in_word),
        .o_valid     (o_valid),
        .i_stall     (out_stall),
        .o_data      (o_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow copy of the registers
    logic [SCALE_W-1:0] r_scale    = RST_MV_PER_COUNT;
    logic [MV_W-1:0]    r_min      = RST_BATT_MIN;
    logic [MV_W-1:0]    r_max      = RST_BATT_MAX;
    logic [MV_W-1:0]    r_alarm    = RST_ALARM_LOW;
    logic [MV_W-1:0]    r_shut     = RST_SHUTDOWN;
    logic               r_auto     = 1'b1;
    logic [MV_W-1:0]    r_interval = RST_INTERVAL;

    // model state of the monitor
    logic [MV_W-1:0]      avg_store [AVG_DEPTH];
    logic [AVG_SHIFT-1:0] avg_slot       = '0;
    logic [SUM_W-1:0]     avg_sum        = '0;
    logic                 avg_primed     = 1'b0;
    logic [TIME_W-1:0]    last_update_ms = '0;
    logic [TIME_W-1:0]    last_warn_ms   = '0;
    logic                 warn_disarmed  = 1'b0;
    logic                 shut_latched   = 1'b0;
    logic [MV_W-1:0]      held_raw       = '0;
    logic [MV_W-1:0]      held_avg       = '0;

    t_in_word  pending_words[$];
    t_out_word expected_readings[$];

    int  mismatch_count  = 0;
    int  words_taken     = 0;
    int  readings_seen   = 0;
    int  warnings_seen   = 0;
    int  shutdowns_seen  = 0;
    int  configs_applied = 0;
    int  quiet_cycles    = 0;
    int  hold_left       = 0;
    bit  hold_done       = 1'b0;
    bit  no_idle         = 1'b0;

    initial begin
        foreach (avg_store[k]) avg_store[k] = '0;
    end

    // linear map of the average onto 0..100, zero when the span is not positive
    function automatic logic [PCT_W-1:0] charge_pct(logic [MV_W-1:0] v);
        logic [MV_W-1:0] c;
        logic [31:0]     q;
        if (r_max <= r_min) return '0;
        c = (v < r_min) ? r_min : ((v > r_max) ? r_max : v);
        q = ((32'(c) - 32'(r_min)) * PCT_SCALE) / (32'(r_max) - 32'(r_min));
        return q[PCT_W-1:0];
    endfunction

    // advance the model by one sample word and return the reading it gives
    function automatic t_out_word monitor_step(t_in_word w);
        t_out_word   r;
        logic        take;
        logic [31:0] prod;
        logic [MV_W-1:0] mv;
        logic        low;
        logic        crit;
        r    = '0;
        take = !avg_primed || ((w.now_ms - last_update_ms) >= 32'(r_interval));
        if (take) begin
            // 12 x 20 bit product fits 32 bits, so the scaled value never clamps
            prod = 32'(w.adc_value) * 32'(r_scale);
            mv   = prod[31:16];
            last_update_ms = w.now_ms;
            if (!avg_primed) begin
                foreach (avg_store[k]) avg_store[k] = mv;
                avg_sum    = SUM_W'(mv) << AVG_SHIFT;
                avg_slot   = '0;
                avg_primed = 1'b1;
            end else begin
                avg_sum = avg_sum - SUM_W'(avg_store[avg_slot]) + SUM_W'(mv);
                avg_store[avg_slot] = mv;
                avg_slot = avg_slot + 1'b1;
            end
            held_raw = mv;
            held_avg = MV_W'(avg_sum >> AVG_SHIFT);
        end
        low  = held_avg <= r_alarm;
        crit = held_avg <= r_shut;
        if (take) begin
            // warning fires once per hold-off window and re-arms on recovery
            if (low && !warn_disarmed && (w.now_ms - last_warn_ms) >= WARN_HOLDOFF_MS) begin
                r.warning_event = 1'b1;
                last_warn_ms    = w.now_ms;
                warn_disarmed   = 1'b1;
            end
            if (!low && warn_disarmed) warn_disarmed = 1'b0;
            if (r_auto && crit && !shut_latched) begin
                shut_latched     = 1'b1;
                r.shutdown_event = 1'b1;
            end
        end
        r.updated     = take;
        r.raw_mv      = held_raw;
        r.avg_mv      = held_avg;
        r.percent     = charge_pct(held_avg);
        r.is_low      = low;
        r.is_critical = crit;
        return r;
    endfunction

    // driver: present queued words, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                expected_readings.push_back(monitor_step(in_word));
                words_taken++;
            end
            if (!in_valid || !o_stall) begin
                if (pending_words.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_word  <= pending_words.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: check result words and drive back-pressure
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_valid && !out_stall) begin
                readings_seen++;
                if (expected_readings.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("updated", 32'(want.updated), 32'(o_data.updated));
                    compare_field("raw_mv", 32'(want.raw_mv), 32'(o_data.raw_mv));
                    compare_field("avg_mv", 32'(want.avg_mv), 32'(o_data.avg_mv));
                    compare_field("percent", 32'(want.percent), 32'(o_data.percent));
                    compare_field("is_low", 32'(want.is_low), 32'(o_data.is_low));
                    compare_field("is_critical", 32'(want.is_critical),
                                  32'(o_data.is_critical));
                    compare_field("warning_event", 32'(want.warning_event),
                                  32'(o_data.warning_event));
                    compare_field("shutdown_event", 32'(want.shutdown_event),
                                  32'(o_data.shutdown_event));
                    warnings_seen  += int'(want.warning_event);
                    shutdowns_seen += int'(want.shutdown_event);
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && readings_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_word(int adc, logic [TIME_W-1:0] now);
        t_in_word w;
        w.adc_value = adc[ADC_W-1:0];
        w.now_ms    = now;
        pending_words.push_back(w);
    endtask

    // block until every queued word is taken and every reading has come back
    task automatic wait_quiet();
        while (pending_words.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_MV_PER_COUNT: r_scale    = value[SCALE_W-1:0];
            CFG_BATT_MIN:     r_min      = value[MV_W-1:0];
            CFG_BATT_MAX:     r_max      = value[MV_W-1:0];
            CFG_ALARM_LOW:    r_alarm    = value[MV_W-1:0];
            CFG_SHUTDOWN:     r_shut     = value[MV_W-1:0];
            CFG_AUTO_SHUT:    r_auto     = value[0];
            CFG_INTERVAL:     r_interval = value[MV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int scale, int lo, int hi, int alarm, int shut,
                              int auto_en, int interval);
        write_reg(CFG_MV_PER_COUNT, CFG_W'(scale));
        write_reg(CFG_BATT_MIN, CFG_W'(lo));
        write_reg(CFG_BATT_MAX, CFG_W'(hi));
        write_reg(CFG_ALARM_LOW, CFG_W'(alarm));
        write_reg(CFG_SHUTDOWN, CFG_W'(shut));
        write_reg(CFG_AUTO_SHUT, CFG_W'(auto_en));
        write_reg(CFG_INTERVAL, CFG_W'(interval));
        write_reg(CFG_SPARE, CFG_W'($urandom()));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        configs_applied++;
    endtask

    task automatic random_config();
        int scale;
        int lo;
        int hi;
        int alarm;
        int interval;
        case ($urandom_range(0, 5))
            0:       scale = 0;
            1:       scale = 'hFFFFF;
            default: scale = $urandom_range(40000, 110000);
        endcase
        lo = $urandom_range(1500, 4000);
        case ($urandom_range(0, 5))
            0:       hi = lo;
            1:       hi = $urandom_range(0, lo);
            default: hi = lo + $urandom_range(1, 2000);
        endcase
        alarm = $urandom_range(2000, 5000);
        case ($urandom_range(0, 5))
            0:       interval = 0;
            1:       interval = 'hFFFF;
            default: interval = $urandom_range(1, 3000);
        endcase
        set_config(scale, lo, hi, alarm, $urandom_range(1500, alarm),
                   $urandom_range(0, 1), interval);
    endtask

    logic [TIME_W-1:0] clock_ms = '0;
    int                level    = 2000;

    // mostly in-order samples drifting around a level, some early, some noise
    task automatic run_phase(int n, bit pause_midway);
        int kind;
        for (int i = 0; i < n; i++) begin
            if (pause_midway && i == n / 2) wait_quiet();
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 29) == 0) level = $urandom_range(0, 4095);
            else level = level + $urandom_range(0, 300) - 150;
            if (level < 0) level = 0;
            if (level > 4095) level = 4095;
            if (kind < 10) begin
                add_word($urandom_range(0, 4095), $urandom());
            end else if (kind < 22) begin
                if (r_interval != 0) clock_ms += $urandom_range(0, r_interval - 1);
                add_word(level, clock_ms);
            end else begin
                clock_ms += 32'(r_interval) + $urandom_range(0, 2500);
                add_word(level, clock_ms);
            end
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: priming, early samples, hold-off, time wrap
        add_word(4095, 32'd0);
        add_word(0, 32'd999);
        add_word(0, 32'd1000);
        add_word(2048, 32'd1500);
        add_word(4095, 32'd12000);
        add_word(0, 32'd13000);
        add_word(0, 32'hFFFF_FFFF);
        add_word(4095, 32'h0000_03E7);
        add_word(1, 32'hAAAA_AAAA);
        add_word(4094, 32'h5555_5555);
        wait_quiet();

        // largest scale, full span, zero interval
        set_config('hFFFFF, 0, 'hFFFF, 0, 0, 0, 0);
        add_word(4095, 32'h5555_5555);
        add_word(0, 32'h5555_5555);
        add_word(4095, 32'h5555_5556);
        add_word(2730, 32'h5555_5556);
        add_word(4095, 32'h0000_0000);
        wait_quiet();

        // zero scale, empty span, longest interval
        set_config(0, 4000, 4000, 'hFFFF, 'hFFFF, 1, 'hFFFF);
        add_word(123, 32'h0001_0000);
        add_word(4095, 32'h0001_5555);
        add_word(0, 32'h0001_FFFE);
        add_word(4095, 32'h0002_0000);
        wait_quiet();

        // span inverted
        set_config(81920, 5000, 100, 3600, 3300, 1, 1);
        add_word(3000, 32'h0003_0000);
        add_word(100, 32'h0003_0001);
        wait_quiet();
        clock_ms = 32'h0003_0001;

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       set_config(81920, 3000, 4500, 3600, 3300, 1, 500);
                1:       set_config(65536, 3300, 4200, 3500, 3300, 0, 0);
                2:       set_config('hFFFFF, 0, 'hFFFF, 'hFFFF, 'hFFFF, 1, 'hFFFF);
                5:       clock_ms = 32'hFFFF_0000;
                default: ;
            endcase
            if (p >= 3) random_config();
            no_idle = (p == 1);
            run_phase(PHASE_WORDS, p == 3);
            wait_quiet();
            no_idle = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d readings from %0d sample words under %0d register settings",
                 readings_seen, words_taken, configs_applied);
        $display("low warnings raised %0d, shutdown events %0d",
                 warnings_seen, shutdowns_seen);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
